[design/bcsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcsc_pkg
// Types, codes and reset values shared by the charge state controller files.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_CABLE  = 2'd1;
  localparam logic [1:0] MODE_TOPOFF = 2'd2;

  localparam logic [1:0] CABLE_NONE   = 2'd0;
  localparam logic [1:0] CABLE_USB    = 2'd1;
  localparam logic [1:0] CABLE_MAINS  = 2'd2;
  localparam logic [1:0] CABLE_REJECT = 2'd3;

  localparam logic [2:0] HEALTH_GOOD     = 3'd1;
  localparam logic [2:0] HEALTH_OVERHEAT = 3'd2;
  localparam logic [2:0] HEALTH_FAILURE  = 3'd6;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_EN   = 2'd1;
  localparam logic [1:0] CMD_DIS  = 2'd2;

  localparam logic [1:0] STC_DIS  = 2'd0;
  localparam logic [1:0] STC_CHG  = 2'd1;
  localparam logic [1:0] STC_FULL = 2'd2;
  localparam logic [1:0] STC_NOT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECH_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECH_VOLT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USB_CUR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAINS_CUR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOPOFF_CUR  = 3'd5;

  localparam logic [31:0] RST_FULL_LIMIT = 32'd2160000;
  localparam logic [31:0] RST_RECH_LIMIT = 32'd720000;
  localparam logic [22:0] RST_RECH_VOLT  = 23'd4130000;
  localparam logic [11:0] RST_USB_CUR    = 12'd450;
  localparam logic [11:0] RST_MAINS_CUR  = 12'd650;
  localparam logic [11:0] RST_TOPOFF_CUR = 12'd200;

  localparam logic [6:0] CAP_FULL = 7'd100;

  typedef enum logic [3:0] {
    STS_DIS  = 4'b0001,
    STS_CHG  = 4'b0010,
    STS_FULL = 4'b0100,
    STS_NOT  = 4'b1000
  } status_e;

  typedef struct packed {
    logic [31:0] full_charge_limit;
    logic [31:0] recharge_limit;
    logic [22:0] recharge_voltage;
    logic [11:0] usb_current;
    logic [11:0] mains_current;
    logic [11:0] topoff_current;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cable;
    status_e     status;
    logic        full_mark;
    logic        recharging;
    logic        start_valid;
  } ctl_t;

  // lowest bits last: {tuser, tdata[66:0]}
  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  charge_level;
    logic [2:0]  health;
    logic [22:0] cell_voltage;
    logic [31:0] now_ticks;
    logic [1:0]  cable_kind;
  } in_t;

  typedef struct packed {
    logic        event_rejected;
    logic        recharge_active;
    logic [31:0] elapsed;
    logic [6:0]  capacity;
    logic [1:0]  charge_status;
    logic [11:0] termination_current;
    logic [11:0] charge_current;
    logic [1:0]  charger_command;
  } res_t;

  localparam int unsigned IN_ITEM_W = $bits(in_t) - IN_USER_W;
  localparam int unsigned RES_W     = $bits(res_t);

  function automatic logic [1:0] status_code(status_e s);
    logic [1:0] c;
    case (s)
      STS_CHG:  c = STC_CHG;
      STS_FULL: c = STC_FULL;
      STS_NOT:  c = STC_NOT;
      default:  c = STC_DIS;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[design/bcsc_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bcsc_step
// Next state and result for one event: safety timers, recharge, health stop
// and recovery, cable change and top-off handling.
// ----------------------------------------------------------------------------
module bcsc_step
  import bcsc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  in_t                   in_i,
  input  cfg_t                  cfg_i,
  input  ctl_t                  ctl_i,
  input  logic [TIME_WIDTH-1:0] start_i,
  input  logic [TIME_WIDTH-1:0] passed_i,
  output ctl_t                  ctl_o,
  output logic [TIME_WIDTH-1:0] start_o,
  output logic [TIME_WIDTH-1:0] passed_o,
  output res_t                  res_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [TIME_WIDTH-1:0] now_w;
  logic [TIME_WIDTH-1:0] elapsed_w;
  logic                  full_expired;
  logic                  rech_expired;

  assign now_w        = TIME_WIDTH'(in_i.now_ticks);
  assign elapsed_w    = now_w - start_i;
  assign full_expired = CMP_W'(elapsed_w) > CMP_W'(cfg_i.full_charge_limit);
  assign rech_expired = CMP_W'(elapsed_w) > CMP_W'(cfg_i.recharge_limit);

  always_comb begin
    ctl_t       c;
    status_e    on_status;
    logic       on_req;
    logic       off_req;
    logic       done;
    logic [1:0] cmd;
    logic [11:0] cur;
    logic [11:0] term;
    logic       rej;
    logic [6:0] level;

    c         = ctl_i;
    start_o   = start_i;
    passed_o  = passed_i;
    on_status = ctl_i.status;
    on_req    = 1'b0;
    off_req   = 1'b0;
    done      = 1'b0;
    cmd       = CMD_NONE;
    cur       = '0;
    term      = '0;
    rej       = 1'b0;

    case (in_i.mode)
      MODE_TICK: begin
        if (c.start_valid) begin
          passed_o = elapsed_w;
          if (c.status == STS_FULL) begin
            if (rech_expired && c.recharging) begin
              off_req      = 1'b1;
              c.recharging = 1'b0;
              done         = 1'b1;
            end
          end else if (c.status == STS_CHG) begin
            if (full_expired) begin
              off_req  = 1'b1;
              c.status = STS_FULL;
              done     = 1'b1;
            end
          end
        end
        if (!done) begin
          if (c.cable == CABLE_NONE && c.status == STS_FULL) begin
            c.status = STS_DIS;
          end
          on_status = c.status;
          case (c.status)
            STS_FULL: begin
              if (in_i.cell_voltage < cfg_i.recharge_voltage && !c.recharging) begin
                c.recharging = 1'b1;
                on_req       = 1'b1;
              end
            end
            STS_CHG: begin
              if (in_i.health inside {[HEALTH_OVERHEAT:HEALTH_FAILURE]}) begin
                off_req      = 1'b1;
                c.status     = STS_NOT;
                c.recharging = 1'b0;
              end
            end
            STS_NOT: begin
              if (in_i.health == HEALTH_GOOD) begin
                if (c.cable != CABLE_NONE) begin
                  on_req   = 1'b1;
                  c.status = STS_CHG;
                end else begin
                  c.status = STS_DIS;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      MODE_CABLE: begin
        if (in_i.cable_kind == CABLE_REJECT) begin
          rej = 1'b1;
        end else begin
          c.cable = in_i.cable_kind;
          if (in_i.cable_kind == CABLE_NONE) begin
            c.full_mark   = 1'b0;
            c.recharging  = 1'b0;
            c.start_valid = 1'b0;
            start_o       = '0;
            c.status      = STS_DIS;
            off_req       = 1'b1;
          end else begin
            on_req   = 1'b1;
            c.status = STS_CHG;
          end
        end
      end
      MODE_TOPOFF: begin
        if (!c.full_mark) begin
          c.recharging = 1'b0;
          c.full_mark  = 1'b1;
          c.status     = STS_FULL;
          cmd          = CMD_DIS;
        end
      end
      default: begin
      end
    endcase

    if (on_req) begin
      c.full_mark = 1'b0;
      if (c.cable == CABLE_USB || c.cable == CABLE_MAINS) begin
        cur  = (c.cable == CABLE_USB) ? cfg_i.usb_current : cfg_i.mains_current;
        term = cfg_i.topoff_current;
        cmd  = CMD_EN;
        if (on_status != STS_CHG) begin
          start_o       = now_w;
          c.start_valid = 1'b1;
        end
      end
    end
    if (off_req) begin
      c.full_mark = 1'b0;
      passed_o    = '0;
      cur         = '0;
      term        = '0;
      cmd         = CMD_DIS;
    end

    level = (in_i.charge_level > CAP_FULL) ? CAP_FULL : in_i.charge_level;

    ctl_o                     = c;
    res_o.charger_command     = cmd;
    res_o.charge_current      = cur;
    res_o.termination_current = term;
    res_o.charge_status       = status_code(c.status);
    res_o.capacity            = (c.status == STS_FULL) ? CAP_FULL : level;
    res_o.elapsed             = 32'(passed_o);
    res_o.recharge_active     = c.recharging;
    res_o.event_rejected      = rej;
  end

endmodule
`default_nettype wire

[design/battery_charge_state_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// battery_charge_state_controller
// Li-ion charge state machine with charge and recharge safety timers.
// ----------------------------------------------------------------------------
// Each beat on the slave side is one event (tick, cable change or top-off)
// and yields exactly one result beat on the master side. A beat is taken into
// an input register, worked through the combinational event logic, and lands
// in a result register, from which the result beat is offered. A new event
// can be taken every cycle while the master side takes the results. The rate
// is set by the update of the controller state, which is registered with the
// result. While a result waits on the master side, the slave side takes one
// more beat into the input register and then stalls. Configuration writes are
// always taken and must be issued only while no event is in flight.
module battery_charge_state_controller
  import bcsc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // cable_kind[1:0], now_ticks[33:2], cell_voltage[56:34], health[59:57],
  // charge_level[66:60], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // charger_command[1:0], charge_current[13:2], termination_current[25:14],
  // charge_status[27:26], capacity[34:28], elapsed[66:35],
  // recharge_active[67], event_rejected[68], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                  cfg_q;
  ctl_t                  ctl_q;
  ctl_t                  ctl_d;
  logic [TIME_WIDTH-1:0] start_q;
  logic [TIME_WIDTH-1:0] start_d;
  logic [TIME_WIDTH-1:0] passed_q;
  logic [TIME_WIDTH-1:0] passed_d;
  logic                  in_valid_q;
  in_t                   in_q;
  logic                  out_valid_q;
  res_t                  out_q;
  res_t                  res_d;
  logic                  out_free;
  logic                  fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out_q};
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_charge_limit <= RST_FULL_LIMIT;
      cfg_q.recharge_limit    <= RST_RECH_LIMIT;
      cfg_q.recharge_voltage  <= RST_RECH_VOLT;
      cfg_q.usb_current       <= RST_USB_CUR;
      cfg_q.mains_current     <= RST_MAINS_CUR;
      cfg_q.topoff_current    <= RST_TOPOFF_CUR;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FULL_LIMIT: cfg_q.full_charge_limit <= cfg_data_i;
        REG_RECH_LIMIT: cfg_q.recharge_limit    <= cfg_data_i;
        REG_RECH_VOLT:  cfg_q.recharge_voltage  <= cfg_data_i[22:0];
        REG_USB_CUR:    cfg_q.usb_current       <= cfg_data_i[11:0];
        REG_MAINS_CUR:  cfg_q.mains_current     <= cfg_data_i[11:0];
        REG_TOPOFF_CUR: cfg_q.topoff_current    <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= {s_axis_tuser, s_axis_tdata[IN_ITEM_W-1:0]};
    end
  end

  bcsc_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .in_i    (in_q),
    .cfg_i   (cfg_q),
    .ctl_i   (ctl_q),
    .start_i (start_q),
    .passed_i(passed_q),
    .ctl_o   (ctl_d),
    .start_o (start_d),
    .passed_o(passed_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.cable       <= CABLE_NONE;
      ctl_q.status      <= STS_DIS;
      ctl_q.full_mark   <= 1'b0;
      ctl_q.recharging  <= 1'b0;
      ctl_q.start_valid <= 1'b0;
      start_q           <= '0;
      passed_q          <= '0;
    end else if (fire) begin
      ctl_q    <= ctl_d;
      start_q  <= start_d;
      passed_q <= passed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed event produced no result beat");

  a_unplug_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.mode == MODE_CABLE && in_q.cable_kind == CABLE_NONE
    |=> !ctl_q.start_valid && ctl_q.status == STS_DIS && passed_q == '0)
    else $error("cable removal left charge state behind");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.mode == MODE_CABLE && in_q.cable_kind == CABLE_REJECT
    |=> $stable(ctl_q) && $stable(start_q) && $stable(passed_q))
    else $error("rejected cable changed state");
`endif

endmodule
`default_nettype wire
